>>> rtl/srr_pkg.sv
// shared constants, types and state encoding of the selective repeat receiver
package srr_pkg;

	// field widths of the packet and result beats
	localparam int SEQ_NUM_W = 3;
	localparam int PAYLOAD_W = 64;

	// default configuration
	localparam int SEQ_SPACE    = 8;
	localparam int WINDOW       = 4;
	localparam int PAYLOAD_BITS = 64;

	// result kind codes
	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_CHECK,
		ST_SLOT,
		ST_ACK
	} state_t;

	// which result the datapath drives onto the output
	typedef enum logic [1:0] {
		SEL_FIRST,
		SEL_SLOT,
		SEL_ACK
	} sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;     // packet beat accepted
		logic advance;  // delivery beat taken: free base slot, step base
		logic count;    // delivery came from a buffered slot
		sel_t sel;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic good;      // arriving packet passed its checksum
		logic in_order;  // arriving packet sits at the window base
		logic more;      // next base slot holds a packet and the run may go on
	} status_t;

endpackage

>>> rtl/srr_ifs.sv
// packet and result channel interfaces

interface srr_in_if;
	logic                           valid;
	logic                           ready;
	logic [srr_pkg::SEQ_NUM_W-1:0]  seq_num;
	logic                           checksum_good;
	logic [srr_pkg::PAYLOAD_W-1:0]  payload;

	modport source(output valid, seq_num, checksum_good, payload, input ready);
	modport sink(input valid, seq_num, checksum_good, payload, output ready);
endinterface

interface srr_out_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [srr_pkg::SEQ_NUM_W-1:0]  ack_number;
	logic [srr_pkg::PAYLOAD_W-1:0]  data_out;
	logic                           last;

	modport source(output valid, kind, ack_number, data_out, last, input ready);
	modport sink(input valid, kind, ack_number, data_out, last, output ready);
endinterface

>>> rtl/srr_ctrl.sv
// controller state machine: packet accept, delivery run and acknowledgement
module srr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_ready,
	input  srr_pkg::status_t status,
	output logic             in_ready,
	output logic             out_valid,
	output srr_pkg::cmd_t    cmd
);

	srr_pkg::state_t state_q;
	srr_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			srr_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!status.good) begin
						state_nxt = srr_pkg::ST_IDLE;
					end else if (status.in_order) begin
						state_nxt = srr_pkg::ST_FIRST;
					end else begin
						state_nxt = srr_pkg::ST_ACK;
					end
				end
			end
			srr_pkg::ST_FIRST: begin
				if (out_ready) begin
					state_nxt = srr_pkg::ST_CHECK;
				end
			end
			srr_pkg::ST_CHECK: begin
				state_nxt = status.more ? srr_pkg::ST_SLOT : srr_pkg::ST_ACK;
			end
			srr_pkg::ST_SLOT: begin
				if (out_ready) begin
					state_nxt = srr_pkg::ST_CHECK;
				end
			end
			srr_pkg::ST_ACK: begin
				if (out_ready) begin
					state_nxt = srr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = srr_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs and commands
	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.load    = 1'b0;
		cmd.advance = 1'b0;
		cmd.count   = 1'b0;
		cmd.sel     = srr_pkg::SEL_ACK;
		case (state_q)
			srr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			srr_pkg::ST_FIRST: begin
				out_valid   = 1'b1;
				cmd.sel     = srr_pkg::SEL_FIRST;
				cmd.advance = out_ready;
			end
			srr_pkg::ST_CHECK: begin
				cmd.sel = srr_pkg::SEL_SLOT;
			end
			srr_pkg::ST_SLOT: begin
				out_valid   = 1'b1;
				cmd.sel     = srr_pkg::SEL_SLOT;
				cmd.advance = out_ready;
				cmd.count   = out_ready;
			end
			srr_pkg::ST_ACK: begin
				out_valid = 1'b1;
				cmd.sel   = srr_pkg::SEL_ACK;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/srr_dp.sv
// datapath: window base, slot valid bits, slot payload memory and result mux
module srr_dp #(
	parameter int SEQ_SPACE    = srr_pkg::SEQ_SPACE,
	parameter int WINDOW       = srr_pkg::WINDOW,
	parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  srr_pkg::cmd_t                  cmd,
	input  logic [srr_pkg::SEQ_NUM_W-1:0]  seq_num,
	input  logic                           checksum_good,
	input  logic [srr_pkg::PAYLOAD_W-1:0]  payload,
	output srr_pkg::status_t               status,
	output logic                           kind,
	output logic [srr_pkg::SEQ_NUM_W-1:0]  ack_number,
	output logic [srr_pkg::PAYLOAD_W-1:0]  data_out,
	output logic                           last
);

	localparam int SEQ_W   = $clog2(SEQ_SPACE);
	localparam int EXTRA_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [SEQ_W-1:0]   BASE_LAST = SEQ_W'(SEQ_SPACE - 1);
	localparam logic [SEQ_W:0]     SPACE_X   = (SEQ_W + 1)'(SEQ_SPACE);
	localparam logic [EXTRA_W-1:0] EXTRA_MAX = EXTRA_W'(WINDOW - 1);

	logic [SEQ_W-1:0]              base_q;
	logic [SEQ_SPACE-1:0]          valid_q;
	logic [EXTRA_W-1:0]            extra_q;
	logic [srr_pkg::SEQ_NUM_W-1:0] seq_q;
	logic [PAYLOAD_BITS-1:0]       data_q;
	logic [PAYLOAD_BITS-1:0]       rd_q;
	logic [PAYLOAD_BITS-1:0]       slot_mem [SEQ_SPACE];

	logic [srr_pkg::SEQ_NUM_W-1:0] seq_in;
	logic [SEQ_W-1:0]              seq_idx;
	logic [SEQ_W:0]                diff;
	logic [SEQ_W:0]                gap;
	logic                          in_window;
	logic                          store;

	// sequence number reduced into the sequence space (one compare and subtract,
	// since the field never reaches twice the sequence space)
	assign seq_in  = (32'(seq_num) >= SEQ_SPACE)
		? srr_pkg::SEQ_NUM_W'(32'(seq_num) - SEQ_SPACE) : seq_num;
	assign seq_idx = SEQ_W'(seq_in);

	// distance from the base, modulo the sequence space
	assign diff = {1'b0, seq_idx} + SPACE_X - {1'b0, base_q};
	assign gap  = (diff >= SPACE_X) ? (diff - SPACE_X) : diff;
	assign in_window = (32'(gap) < WINDOW);

	// out-of-order packet inside the window with a free slot
	assign store = cmd.load && checksum_good && (seq_idx != base_q) && in_window
		&& !valid_q[seq_idx];

	assign status.good     = checksum_good;
	assign status.in_order = (seq_idx == base_q);
	assign status.more     = (extra_q < EXTRA_MAX) && valid_q[base_q];

	// window base, slot valid bits and run length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			valid_q <= '0;
			extra_q <= '0;
		end else begin
			if (cmd.load) begin
				extra_q <= '0;
			end else if (cmd.count) begin
				extra_q <= extra_q + 1'b1;
			end
			if (store) begin
				valid_q[seq_idx] <= 1'b1;
			end
			if (cmd.advance) begin
				valid_q[base_q] <= 1'b0;
				base_q <= (base_q == BASE_LAST) ? '0 : (base_q + 1'b1);
			end
		end
	end

	// accepted packet fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q  <= seq_in;
			data_q <= payload[PAYLOAD_BITS-1:0];
		end
	end

	// slot payload memory, read at the window base
	always_ff @(posedge clk) begin
		if (store) begin
			slot_mem[seq_idx] <= payload[PAYLOAD_BITS-1:0];
		end
		rd_q <= slot_mem[base_q];
	end

	// result fields
	always_comb begin
		kind       = srr_pkg::KIND_DELIVER;
		ack_number = '0;
		data_out   = '0;
		last       = 1'b0;
		case (cmd.sel)
			srr_pkg::SEL_FIRST: begin
				data_out = srr_pkg::PAYLOAD_W'(data_q);
			end
			srr_pkg::SEL_SLOT: begin
				data_out = srr_pkg::PAYLOAD_W'(rd_q);
			end
			srr_pkg::SEL_ACK: begin
				kind       = srr_pkg::KIND_ACK;
				ack_number = seq_q;
				last       = 1'b1;
			end
			default: begin
				kind = srr_pkg::KIND_DELIVER;
			end
		endcase
	end

endmodule

>>> rtl/selective_repeat_receiver.sv
// Selective repeat receiver top level. One packet beat is taken at a time. A packet
// with a bad checksum is dropped. A good packet outside the window base is stored in
// the slot of its sequence number (if inside the window and the slot is free) and
// acknowledged. A packet at the base is delivered, then the buffered packets that
// follow it are delivered, each after one registered read of the slot memory at the
// new base, and the packet ends with its acknowledgement (last set). At most
// WINDOW - 1 buffered packets are delivered per packet, and each result waits while
// the result sink holds ready low.
module selective_repeat_receiver #(
	parameter int SEQ_SPACE    = srr_pkg::SEQ_SPACE,
	parameter int WINDOW       = srr_pkg::WINDOW,
	parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	srr_in_if.sink       pkt,
	srr_out_if.source    res
);

	srr_pkg::cmd_t    cmd;
	srr_pkg::status_t status;

	// sequencing
	srr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pkt.valid),
		.out_ready (res.ready),
		.status    (status),
		.in_ready  (pkt.ready),
		.out_valid (res.valid),
		.cmd       (cmd)
	);

	// window state and result fields
	srr_dp #(
		.SEQ_SPACE    (SEQ_SPACE),
		.WINDOW       (WINDOW),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.seq_num       (pkt.seq_num),
		.checksum_good (pkt.checksum_good),
		.payload       (pkt.payload),
		.status        (status),
		.kind          (res.kind),
		.ack_number    (res.ack_number),
		.data_out      (res.data_out),
		.last          (res.last)
	);

endmodule
